// ----- hdl/adaptive_hysteresis_pulse_counter_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive hysteresis pulse counter.
// Every macro samples on clk_i and is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_HYSTERESIS_PULSE_COUNTER_MACROS_SVH
`define ADAPTIVE_HYSTERESIS_PULSE_COUNTER_MACROS_SVH

// Same-cycle implication.
`define AHPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ahpc: assertion failed");

// Next-cycle implication.
`define AHPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ahpc: assertion failed");

`endif

// ----- hdl/ahpc_pkg.sv -----
// ----------------------------------------------------------------------------
// ahpc_pkg
// Shared constants for the adaptive hysteresis pulse counter.
// ----------------------------------------------------------------------------
package ahpc_pkg;

  // Default geometry.
  localparam int unsigned WINDOW_DEF      = 32;
  localparam int unsigned SAMPLE_BITS_DEF = 12;

  // Fixed field widths.
  localparam int unsigned THR_W   = 11;
  localparam int unsigned PULSE_W = 31;
  localparam int unsigned TC_W    = 32;
  localparam int unsigned UPPER_W = 5;
  localparam int unsigned LOWER_W = 4;
  localparam int unsigned DEC_W   = 3;
  localparam int unsigned TURN_W  = 3;

  localparam logic [THR_W-1:0] THR_MAX = '1;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC   = 2'd2;

  localparam logic [UPPER_W-1:0] UPPER_RST = 5'd11;
  localparam logic [LOWER_W-1:0] LOWER_RST = 4'd9;
  localparam logic [DEC_W-1:0]   DEC_RST   = 3'd4;

endpackage

// ----- hdl/ahpc_in_if.sv -----
// ----------------------------------------------------------------------------
// ahpc_in_if
// Sample channel: one converter sample per beat.
// ----------------------------------------------------------------------------
interface ahpc_in_if #(
  parameter int unsigned SAMPLE_BITS = ahpc_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- hdl/ahpc_out_if.sv -----
// ----------------------------------------------------------------------------
// ahpc_out_if
// Result channel: classification state, pulse count and threshold per beat.
// ----------------------------------------------------------------------------
interface ahpc_out_if;
  import ahpc_pkg::*;

  logic               valid;
  logic               ready;
  logic               ready_res;
  logic               level;
  logic [PULSE_W-1:0] pulses;
  logic [THR_W-1:0]   threshold;

  modport source (output valid, output ready_res, output level, output pulses,
                  output threshold, input ready);
  modport sink   (input valid, input ready_res, input level, input pulses,
                  input threshold, output ready);
endinterface

// ----- hdl/ahpc_ram.sv -----
// ----------------------------------------------------------------------------
// ahpc_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module ahpc_ram #(
  parameter int unsigned WIDTH = ahpc_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned DEPTH = ahpc_pkg::WINDOW_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- hdl/ahpc_div.sv -----
// ----------------------------------------------------------------------------
// ahpc_div
// Division by a power-of-two constant as a registered right shift. The
// quotient and done follow start in the next cycle. DIVISOR must be a power of two.
// ----------------------------------------------------------------------------
module ahpc_div #(
  parameter int unsigned DW      = 2 * ahpc_pkg::SAMPLE_BITS_DEF + 5,
  parameter int unsigned DIVISOR = ahpc_pkg::WINDOW_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);
  localparam int unsigned SH = $clog2(DIVISOR);

  logic          done_q;
  logic [DW-1:0] quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  // The quotient holds until the next start.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i >> SH;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

// ----- hdl/ahpc_isqrt.sv -----
// ----------------------------------------------------------------------------
// ahpc_isqrt
// Digit-by-digit integer square root, one root bit a cycle.
// ----------------------------------------------------------------------------
module ahpc_isqrt #(
  parameter int unsigned N = ahpc_pkg::SAMPLE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [2*N-1:0] radicand_i,
  output logic           done_o,
  output logic [N-1:0]   root_o
);
  localparam int unsigned CW = $clog2(N + 1);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [2*N-1:0] val_q, val_d;
  logic [N+1:0]   rem_q, rem_d;
  logic [N-1:0]   root_q, root_d;
  logic [N+1:0]   cur;
  logic [N+1:0]   trial;
  logic           ge;

  // The partial remainder stays below 2^N until the last step.
  assign cur   = {rem_q[N-1:0], val_q[2*N-1 -: 2]};
  assign trial = {root_q, 2'b01};
  assign ge    = cur >= trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(N);
      val_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? (cur - trial) : cur;
      root_d = {root_q[N-2:0], ge};
      val_d  = {val_q[2*N-3:0], 2'b00};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// ----- hdl/adaptive_hysteresis_pulse_counter.sv -----
// A warmup sample goes through the FINISH state to the result register, a classified one
// through CLASS and then FINISH. A new sample is taken only once the last result is loaded,
// which waits while an earlier result is not taken. A sample that closes the window shows its
// result after the two read passes over the window RAM, the divider and the square-root unit.
// WINDOW must be a power of two, so the averages are shifts.
// Reset clears all control state; the window RAM is not cleared, warmup fills it first.
// ----------------------------------------------------------------------------
// adaptive_hysteresis_pulse_counter
// Hysteresis comparator with a threshold taken from the standard deviation
// of a window of samples, counting full pulses.
// ----------------------------------------------------------------------------
module adaptive_hysteresis_pulse_counter #(
  parameter int unsigned WINDOW      = ahpc_pkg::WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = ahpc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ahpc_in_if.sink                          in_i,
  ahpc_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [ahpc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ahpc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ahpc_pkg::*;

  localparam int unsigned IDX_W  = $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned ACC_W  = 2 * SAMPLE_BITS + $clog2(WINDOW);
  localparam int unsigned SQ_W   = 2 * SAMPLE_BITS;
  localparam int unsigned SCL_W  = SAMPLE_BITS + 4;
  localparam int unsigned LIM_W  = UPPER_W + THR_W;
  localparam int unsigned CMP_W  = (SCL_W > LIM_W) ? SCL_W : LIM_W;
  localparam int unsigned SAT_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLASS  = 3'd1;
  localparam logic [2:0] ST_SUM    = 3'd2;
  localparam logic [2:0] ST_DIV1   = 3'd3;
  localparam logic [2:0] ST_SQ     = 3'd4;
  localparam logic [2:0] ST_DIV2   = 3'd5;
  localparam logic [2:0] ST_SQRT   = 3'd6;
  localparam logic [2:0] ST_FINISH = 3'd7;

  // Control state.
  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       warm_q, warm_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [THR_W-1:0]       thr_q, thr_d;
  logic                   level_q, level_d;
  logic [TC_W-1:0]        tc_q, tc_d;
  logic [TURN_W-1:0]      turn_q, turn_d;
  logic                   ret_class_q, ret_class_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   rvld_q, rvld_d;
  logic                   pvld_q, pvld_d;
  logic                   out_valid_q, out_valid_d;
  logic [UPPER_W-1:0]     upper_q;
  logic [LOWER_W-1:0]     lower_q;
  logic [DEC_W-1:0]       dec_q;

  // Datapath registers.
  logic [SAMPLE_BITS-1:0] x_q, x_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic [SAMPLE_BITS-1:0] mean_q, mean_d;
  logic [SQ_W-1:0]        prod_q, prod_d;
  logic                   res_ready_q;
  logic                   res_level_q;
  logic [PULSE_W-1:0]     res_pulses_q;
  logic [THR_W-1:0]       res_thr_q;

  // Window RAM and arithmetic units.
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic                   mem_re;
  logic [SAMPLE_BITS-1:0] mem_rdata;
  logic                   div_start;
  logic                   div_done;
  logic [ACC_W-1:0]       div_quo;
  logic                   sqrt_start;
  logic                   sqrt_done;
  logic [SAMPLE_BITS-1:0] sqrt_root;

  logic                   in_beat;
  logic                   out_load;
  logic [CMP_W-1:0]       scaled;
  logic [LIM_W-1:0]       hi_lim;
  logic [LIM_W-1:0]       lo_lim;
  logic                   lvl_next;
  logic [TURN_W-1:0]      turn_inc;
  logic [SAMPLE_BITS-1:0] dev;
  logic [SAT_W-1:0]       root_ext;
  logic [THR_W-1:0]       thr_sat;
  logic                   last_idx;
  logic                   warm_full;

  ahpc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (mem_rdata)
  );

  ahpc_div #(
    .DW      (ACC_W),
    .DIVISOR (WINDOW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  ahpc_isqrt #(
    .N (SAMPLE_BITS)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (div_quo[SQ_W-1:0]),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_beat    = in_i.valid && in_i.ready;
  assign last_idx   = (idx_q == IDX_W'(WINDOW - 1));
  assign warm_full  = (warm_q == CNT_W'(WINDOW));

  // Hysteresis test: high when 10x exceeds upper*thr, low when below lower*thr.
  // The low test wins when both hold.
  assign scaled   = CMP_W'(x_q) * CMP_W'(4'd10);
  assign hi_lim   = LIM_W'(upper_q) * LIM_W'(thr_q);
  assign lo_lim   = LIM_W'(lower_q) * LIM_W'(thr_q);
  always_comb begin
    lvl_next = level_q;
    if (scaled > CMP_W'(hi_lim)) begin
      lvl_next = 1'b1;
    end
    if (scaled < CMP_W'(lo_lim)) begin
      lvl_next = 1'b0;
    end
  end
  assign turn_inc = turn_q + 1'b1;

  // Absolute deviation from the floored mean, for the second pass.
  assign dev = (mem_rdata >= mean_q) ? (mem_rdata - mean_q) : (mean_q - mem_rdata);

  // The root can exceed the threshold field only for wide samples; it saturates.
  assign root_ext = SAT_W'(sqrt_root);
  assign thr_sat  = (root_ext > SAT_W'(THR_MAX)) ? THR_MAX : root_ext[THR_W-1:0];

  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d     = state_q;
    warm_d      = warm_q;
    idx_d       = idx_q;
    thr_d       = thr_q;
    level_d     = level_q;
    tc_d        = tc_q;
    turn_d      = turn_q;
    ret_class_d = ret_class_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    acc_d       = acc_q;
    mean_d      = mean_q;
    prod_d      = prod_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = x_q;
    mem_re      = 1'b0;
    div_start   = 1'b0;
    sqrt_start  = 1'b0;
    pvld_d      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          x_d = in_i.sample;
          if (!warm_full) begin
            // Warmup: every sample goes into the window.
            warm_d    = warm_q + 1'b1;
            mem_we    = 1'b1;
            mem_wdata = in_i.sample;
            if (last_idx) begin
              // The window is full: recalibrate, then classify this sample.
              idx_d       = '0;
              ret_class_d = 1'b1;
              cnt_d       = '0;
              acc_d       = '0;
              state_d     = ST_SUM;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = ST_FINISH;
            end
          end else begin
            state_d = ST_CLASS;
          end
        end
      end

      ST_CLASS: begin
        level_d = lvl_next;
        if (lvl_next != level_q) begin
          tc_d = tc_q + 1'b1;
        end
        state_d = ST_FINISH;
        if (turn_inc == dec_q) begin
          // Decimated sample feeds the window.
          turn_d = '0;
          mem_we = 1'b1;
          if (last_idx) begin
            idx_d       = '0;
            ret_class_d = 1'b0;
            cnt_d       = '0;
            acc_d       = '0;
            state_d     = ST_SUM;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          turn_d = turn_inc;
        end
      end

      ST_SUM: begin
        mem_re = (cnt_q < CNT_W'(WINDOW));
        if (mem_re) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (rvld_q) begin
          acc_d = acc_q + ACC_W'(mem_rdata);
        end
        if (!mem_re && !rvld_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV1;
        end
      end

      ST_DIV1: begin
        if (div_done) begin
          mean_d  = div_quo[SAMPLE_BITS-1:0];
          cnt_d   = '0;
          acc_d   = '0;
          state_d = ST_SQ;
        end
      end

      ST_SQ: begin
        mem_re = (cnt_q < CNT_W'(WINDOW));
        if (mem_re) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (rvld_q) begin
          prod_d = SQ_W'(dev) * SQ_W'(dev);
          pvld_d = 1'b1;
        end
        if (pvld_q) begin
          acc_d = acc_q + ACC_W'(prod_q);
        end
        if (!mem_re && !rvld_q && !pvld_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV2;
        end
      end

      ST_DIV2: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_d    = ST_SQRT;
        end
      end

      ST_SQRT: begin
        if (sqrt_done) begin
          thr_d   = thr_sat;
          state_d = ret_class_q ? ST_CLASS : ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rvld_d = mem_re;

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      warm_q      <= '0;
      idx_q       <= '0;
      thr_q       <= '0;
      level_q     <= 1'b0;
      tc_q        <= '0;
      turn_q      <= '0;
      ret_class_q <= 1'b0;
      cnt_q       <= '0;
      rvld_q      <= 1'b0;
      pvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      upper_q     <= UPPER_RST;
      lower_q     <= LOWER_RST;
      dec_q       <= DEC_RST;
    end else begin
      state_q     <= state_d;
      warm_q      <= warm_d;
      idx_q       <= idx_d;
      thr_q       <= thr_d;
      level_q     <= level_d;
      tc_q        <= tc_d;
      turn_q      <= turn_d;
      ret_class_q <= ret_class_d;
      cnt_q       <= cnt_d;
      rvld_q      <= rvld_d;
      pvld_q      <= pvld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_UPPER: upper_q <= cfg_data_i[UPPER_W-1:0];
          CFG_LOWER: lower_q <= cfg_data_i[LOWER_W-1:0];
          CFG_DEC:   dec_q   <= cfg_data_i[DEC_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    acc_q  <= acc_d;
    mean_q <= mean_d;
    prod_q <= prod_d;
    if (out_load) begin
      res_ready_q  <= warm_full;
      res_level_q  <= level_q;
      res_pulses_q <= tc_q[TC_W-1:1];
      res_thr_q    <= thr_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.ready_res = res_ready_q;
  assign out_o.level     = res_level_q;
  assign out_o.pulses    = res_pulses_q;
  assign out_o.threshold = res_thr_q;
endmodule

// ----- hdl/ahpc_chk.sv -----
// ----------------------------------------------------------------------------
// ahpc_chk
// Port-level checks of the result stream of the pulse counter.
// ----------------------------------------------------------------------------
`include "adaptive_hysteresis_pulse_counter_macros.svh"

module ahpc_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          ready_res_i,
  input logic                          level_i,
  input logic [ahpc_pkg::PULSE_W-1:0]  pulses_i,
  input logic [ahpc_pkg::THR_W-1:0]    threshold_i
);
  import ahpc_pkg::*;

  logic               out_beat;
  logic               seen_q;
  logic               last_rr_q;
  logic [PULSE_W-1:0] last_pulses_q;
  logic [PULSE_W-1:0] pulses_inc;

  assign out_beat   = out_valid_i && out_ready_i;
  assign pulses_inc = last_pulses_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q        <= 1'b0;
      last_rr_q     <= 1'b0;
      last_pulses_q <= '0;
    end else if (out_beat) begin
      seen_q        <= 1'b1;
      last_rr_q     <= ready_res_i;
      last_pulses_q <= pulses_i;
    end
  end

  // A stalled result holds.
  `AHPC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(ready_res_i) && $stable(level_i) && $stable(pulses_i) && $stable(threshold_i))

  // During warmup the level and count keep their reset values.
  `AHPC_ASSERT_IMP(a_warm_quiet, out_valid_i && !ready_res_i, !level_i && (pulses_i == '0))

  // One sample adds at most one transition, so pulses step by zero or one.
  `AHPC_ASSERT_IMP(a_pulse_step, out_beat && seen_q, (pulses_i == last_pulses_q) || (pulses_i == pulses_inc))

  // Once classification runs it keeps running until reset.
  `AHPC_ASSERT_IMP(a_ready_sticky, out_beat && seen_q && last_rr_q, ready_res_i)
endmodule

bind adaptive_hysteresis_pulse_counter ahpc_chk u_ahpc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .ready_res_i (out_o.ready_res),
  .level_i     (out_o.level),
  .pulses_i    (out_o.pulses),
  .threshold_i (out_o.threshold)
);
